>>> design/lrp_pkg.sv
`default_nettype none

package lrp_pkg;

    // Default coordinate width; rectangle sizes are masked to this many bits.
    localparam int COORD_BITS = 16;
    // Default depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    localparam int SIZE_W  = 16;   // rectangle width or height
    localparam int PAD_W   = 10;   // border and shape padding
    localparam int POS_W   = 18;   // cursors and line extent
    localparam int MAX_W   = 18;   // signed usable extent
    localparam int CMP_W   = 21;   // signed width for overrun compares
    localparam int PLACE_W = 17;   // output coordinates
    localparam int SHEET_W = 16;   // sheet counter
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HORIZONTAL       = 3'd0,
        CFG_SHEET_MAX_WIDTH  = 3'd1,
        CFG_SHEET_MAX_HEIGHT = 3'd2,
        CFG_BORDER_PAD       = 3'd3,
        CFG_GAP_PAD          = 3'd4
    } cfg_index_t;

    // Padding settings that the back needs while placing.
    typedef struct packed {
        logic [PAD_W-1:0] border_pad;
        logic [PAD_W-1:0] gap_pad;
    } pad_cfg_t;

    // One classified request, oriented along and across the current line.
    typedef struct packed {
        logic                     start;
        logic                     horiz;
        logic [SIZE_W-1:0]        size_d;
        logic [SIZE_W-1:0]        size_p;
        logic signed [MAX_W-1:0]  max_d;
        logic signed [MAX_W-1:0]  max_p;
        logic                     too_d;
        logic                     too_p;
    } item_t;

endpackage

`default_nettype wire

>>> design/lrp_rect_if.sv
`default_nettype none

interface lrp_rect_if;
    logic                       valid;
    logic                       ready;
    logic                       start_of_set;
    logic [lrp_pkg::SIZE_W-1:0] rect_width;
    logic [lrp_pkg::SIZE_W-1:0] rect_height;

    modport source (output valid, output start_of_set, output rect_width,
                    output rect_height, input ready);
    modport sink (input valid, input start_of_set, input rect_width,
                  input rect_height, output ready);
endinterface

`default_nettype wire

>>> design/lrp_place_if.sv
`default_nettype none

interface lrp_place_if;
    logic                        valid;
    logic                        ready;
    logic [lrp_pkg::PLACE_W-1:0] place_x;
    logic [lrp_pkg::PLACE_W-1:0] place_y;
    logic [lrp_pkg::SHEET_W-1:0] sheet_index;
    logic                        new_sheet;
    logic                        not_placed;

    modport source (output valid, output place_x, output place_y, output sheet_index,
                    output new_sheet, output not_placed, input ready);
    modport sink (input valid, input place_x, input place_y, input sheet_index,
                  input new_sheet, input not_placed, output ready);
endinterface

`default_nettype wire

>>> design/lrp_cfg_if.sv
`default_nettype none

interface lrp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lrp_pkg::CFG_IDX_W-1:0]  index;
    logic [lrp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/lrp_front.sv
`default_nettype none

module lrp_front #(
    parameter int COORD_BITS = lrp_pkg::COORD_BITS
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    lrp_rect_if.sink           rect,
    lrp_cfg_if.sink            cfg,
    output logic               push_valid,
    input  wire logic          push_ready,
    output lrp_pkg::item_t     push_item,
    output lrp_pkg::pad_cfg_t  pad_cfg
);

    localparam int EFF_BITS = (COORD_BITS < lrp_pkg::SIZE_W) ? COORD_BITS : lrp_pkg::SIZE_W;
    localparam logic [lrp_pkg::SIZE_W-1:0] SIZE_MASK =
        lrp_pkg::SIZE_W'((64'd1 << EFF_BITS) - 64'd1);

    logic                        horizontal_reg;
    logic [lrp_pkg::SIZE_W-1:0]  sheet_max_width_reg;
    logic [lrp_pkg::SIZE_W-1:0]  sheet_max_height_reg;
    logic [lrp_pkg::PAD_W-1:0]   border_pad_reg;
    logic [lrp_pkg::PAD_W-1:0]   gap_pad_reg;

    logic [lrp_pkg::SIZE_W-1:0]        w;
    logic [lrp_pkg::SIZE_W-1:0]        h;
    logic signed [lrp_pkg::MAX_W-1:0]  max_w;
    logic signed [lrp_pkg::MAX_W-1:0]  max_h;
    logic signed [lrp_pkg::MAX_W-1:0]  size_d_s;
    logic signed [lrp_pkg::MAX_W-1:0]  size_p_s;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            horizontal_reg       <= 1'b1;
            sheet_max_width_reg  <= lrp_pkg::SIZE_W'(4096);
            sheet_max_height_reg <= lrp_pkg::SIZE_W'(4096);
            border_pad_reg       <= '0;
            gap_pad_reg          <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                lrp_pkg::CFG_HORIZONTAL:       horizontal_reg       <= cfg.data[0];
                lrp_pkg::CFG_SHEET_MAX_WIDTH:  sheet_max_width_reg  <= cfg.data;
                lrp_pkg::CFG_SHEET_MAX_HEIGHT: sheet_max_height_reg <= cfg.data;
                lrp_pkg::CFG_BORDER_PAD:
                    border_pad_reg <= cfg.data[lrp_pkg::PAD_W-1:0];
                lrp_pkg::CFG_GAP_PAD:
                    gap_pad_reg <= cfg.data[lrp_pkg::PAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Usable extent is the sheet size less the border on both sides; it may go negative.
    always_comb
    begin
        w = rect.rect_width & SIZE_MASK;
        h = rect.rect_height & SIZE_MASK;
        max_w = $signed({2'b00, sheet_max_width_reg})
              - $signed({{(lrp_pkg::MAX_W - lrp_pkg::PAD_W - 1){1'b0}},
                         border_pad_reg, 1'b0});
        max_h = $signed({2'b00, sheet_max_height_reg})
              - $signed({{(lrp_pkg::MAX_W - lrp_pkg::PAD_W - 1){1'b0}},
                         border_pad_reg, 1'b0});

        push_item.start  = rect.start_of_set;
        push_item.horiz  = horizontal_reg;
        push_item.size_d = horizontal_reg ? w : h;
        push_item.size_p = horizontal_reg ? h : w;
        push_item.max_d  = horizontal_reg ? max_w : max_h;
        push_item.max_p  = horizontal_reg ? max_h : max_w;

        size_d_s = $signed({2'b00, push_item.size_d});
        size_p_s = $signed({2'b00, push_item.size_p});
        push_item.too_d = size_d_s > push_item.max_d;
        push_item.too_p = size_p_s > push_item.max_p;
    end

    assign push_valid = rect.valid;
    assign rect.ready = push_ready;

    assign pad_cfg.border_pad = border_pad_reg;
    assign pad_cfg.gap_pad    = gap_pad_reg;

endmodule

`default_nettype wire

>>> design/lrp_queue.sv
`default_nettype none

module lrp_queue #(
    parameter int DEPTH = lrp_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire lrp_pkg::item_t  push_item,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output lrp_pkg::item_t       pop_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lrp_pkg::item_t    mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

>>> design/lrp_back.sv
`default_nettype none

module lrp_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pop_valid,
    output logic                    pop_ready,
    input  wire lrp_pkg::item_t     pop_item,
    input  wire lrp_pkg::pad_cfg_t  pad_cfg,
    lrp_place_if.source             place
);

    localparam int CW = lrp_pkg::CMP_W;
    localparam int PW = lrp_pkg::POS_W;

    logic [PW-1:0]                along_reg, along_next;
    logic [PW-1:0]                across_reg, across_next;
    logic [PW-1:0]                line_reg, line_next;
    logic [lrp_pkg::SHEET_W-1:0]  sheet_reg, sheet_next;
    logic                         failed_reg, failed_next;

    logic                         out_valid_reg;
    logic [lrp_pkg::PLACE_W-1:0]  x_reg, x_next;
    logic [lrp_pkg::PLACE_W-1:0]  y_reg, y_next;
    logic [lrp_pkg::SHEET_W-1:0]  index_reg, index_next;
    logic                         new_sheet_reg, new_sheet_next;
    logic                         not_placed_reg, not_placed_next;

    logic [PW-1:0]                cur_d, cur_p, cur_line;
    logic [lrp_pkg::SHEET_W-1:0]  cur_sheet;
    logic                         cur_failed;
    logic signed [CW-1:0]         max_d_x, max_p_x;
    logic                         line_adv, ov_keep, ov_line, sheet_adv, fail;
    logic [PW-1:0]                pos_d, pos_p, line_n, pos_x, pos_y, cand;
    logic                         take;

    assign take      = pop_valid && pop_ready;
    assign pop_ready = !out_valid_reg || place.ready;

    always_comb
    begin
        // A start flag clears the packing state before this rectangle is placed.
        cur_d      = pop_item.start ? '0 : along_reg;
        cur_p      = pop_item.start ? '0 : across_reg;
        cur_line   = pop_item.start ? '0 : line_reg;
        cur_sheet  = pop_item.start ? '0 : sheet_reg;
        cur_failed = pop_item.start ? 1'b0 : failed_reg;

        max_d_x = CW'(pop_item.max_d);
        max_p_x = CW'(pop_item.max_p);

        line_adv = $signed({3'b000, cur_d} + CW'(pop_item.size_d)) > max_d_x;
        ov_keep  = $signed({3'b000, cur_p} + CW'(pop_item.size_p)) > max_p_x;
        ov_line  = $signed({3'b000, cur_p} + {3'b000, cur_line} + CW'(pop_item.size_p))
                   > max_p_x;
        sheet_adv = line_adv ? ov_line : ov_keep;

        pos_d  = (line_adv || sheet_adv) ? '0 : cur_d;
        pos_p  = sheet_adv ? '0 : (line_adv ? cur_p + cur_line : cur_p);
        line_n = (line_adv || sheet_adv) ? '0 : cur_line;

        // After an advance the rectangle sits at the line or sheet origin, so only
        // its own size against the usable extent decides whether it fits.
        fail = ((line_adv || sheet_adv) && pop_item.too_d) || (sheet_adv && pop_item.too_p);

        pos_x = pop_item.horiz ? pos_d : pos_p;
        pos_y = pop_item.horiz ? pos_p : pos_d;
        cand  = PW'(pop_item.size_p) + PW'(pad_cfg.gap_pad);

        along_next      = along_reg;
        across_next     = across_reg;
        line_next       = line_reg;
        sheet_next      = sheet_reg;
        failed_next     = failed_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        index_next      = index_reg;
        new_sheet_next  = new_sheet_reg;
        not_placed_next = not_placed_reg;

        if (take)
        begin
            new_sheet_next  = 1'b0;
            not_placed_next = 1'b1;
            x_next          = '0;
            y_next          = '0;
            if (cur_failed)
            begin
                along_next  = cur_d;
                across_next = cur_p;
                line_next   = cur_line;
                sheet_next  = cur_sheet;
                failed_next = 1'b1;
                index_next  = cur_sheet;
            end
            else
            begin
                sheet_next  = sheet_adv ? cur_sheet + 1'b1 : cur_sheet;
                index_next  = sheet_next;
                across_next = pos_p;
                if (fail)
                begin
                    failed_next = 1'b1;
                    along_next  = pos_d;
                    line_next   = line_n;
                end
                else
                begin
                    failed_next     = 1'b0;
                    not_placed_next = 1'b0;
                    new_sheet_next  = sheet_adv;
                    x_next = lrp_pkg::PLACE_W'(pos_x + PW'(pad_cfg.border_pad));
                    y_next = lrp_pkg::PLACE_W'(pos_y + PW'(pad_cfg.border_pad));
                    along_next = pos_d + PW'(pop_item.size_d) + PW'(pad_cfg.gap_pad);
                    line_next  = (cand > line_n) ? cand : line_n;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            along_reg     <= '0;
            across_reg    <= '0;
            line_reg      <= '0;
            sheet_reg     <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            along_reg  <= along_next;
            across_reg <= across_next;
            line_reg   <= line_next;
            sheet_reg  <= sheet_next;
            failed_reg <= failed_next;
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (place.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        y_reg          <= y_next;
        index_reg      <= index_next;
        new_sheet_reg  <= new_sheet_next;
        not_placed_reg <= not_placed_next;
    end

    assign place.valid       = out_valid_reg;
    assign place.place_x     = x_reg;
    assign place.place_y     = y_reg;
    assign place.sheet_index = index_reg;
    assign place.new_sheet   = new_sheet_reg;
    assign place.not_placed  = not_placed_reg;

endmodule

`default_nettype wire

>>> design/line_rectangle_packer.sv
// Path: a request goes into the queue, then the back end loads its result into the
// output register. Throughput: one rectangle per cycle while the consumer is ready,
// set by the back end's placement step; the queue lets either side stall on its own.
// Reset: rst_n is asynchronous and active low; it restores the register defaults,
// clears the cursors, line extent, sheet count and error, and empties the queue.
`default_nettype none

module line_rectangle_packer #(
    parameter int COORD_BITS  = lrp_pkg::COORD_BITS,
    parameter int QUEUE_DEPTH = lrp_pkg::QUEUE_DEPTH
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    lrp_rect_if.sink     rect,
    lrp_place_if.source  place,
    lrp_cfg_if.sink      cfg
);

    // The front holds the configuration registers and turns each request into
    // along/across terms for the current orientation. It also precomputes whether
    // the rectangle alone is larger than the usable sheet, which depends only on the
    // rectangle and the configuration, so the back end does not have to.
    logic               push_valid;
    logic               push_ready;
    lrp_pkg::item_t     push_item;
    lrp_pkg::pad_cfg_t  pad_cfg;

    // Requests waiting between the front and the back.
    logic               pop_valid;
    logic               pop_ready;
    lrp_pkg::item_t     pop_item;

    lrp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rect       (rect),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pad_cfg    (pad_cfg)
    );

    lrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // The back owns the packing state. Each cycle it can take one request, decide
    // whether a new line or a new sheet is needed, and load the output register,
    // which it refills in the same cycle that the consumer takes the old result.
    lrp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .pad_cfg   (pad_cfg),
        .place     (place)
    );

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // One rectangle request as the driver presents it.
    typedef struct packed {
        logic                       start_of_set;
        logic [lrp_pkg::SIZE_W-1:0] rect_width;
        logic [lrp_pkg::SIZE_W-1:0] rect_height;
    } rect_req_t;

    // One placement as the block should report it.
    typedef struct packed {
        logic [lrp_pkg::PLACE_W-1:0] place_x;
        logic [lrp_pkg::PLACE_W-1:0] place_y;
        logic [lrp_pkg::SHEET_W-1:0] sheet_index;
        logic                        new_sheet;
        logic                        not_placed;
    } placement_t;

    localparam longint COORD_MASK = (longint'(1) << lrp_pkg::COORD_BITS) - 1;

    logic clk;
    logic rst_n;

    lrp_rect_if  rect_bus ();
    lrp_place_if place_bus ();
    lrp_cfg_if   cfg_bus ();

    line_rectangle_packer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rect  (rect_bus),
        .place (place_bus),
        .cfg   (cfg_bus)
    );

    // Requests waiting to be driven, and placements still owed by the block.
    rect_req_t  pending_rects[$];
    placement_t expected_places[$];

    // Idling controls. The stimulus process sets the percentages per phase; the two hold
    // flags let it freeze one side entirely for the back-pressure scenarios.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    logic        send_hold;
    logic        recv_hold;

    // Bookkeeping for the final report.
    int mismatches;
    int placements_checked;
    int sheets_opened;
    int rejects_seen;

    // Our own copy of the register file, mirrored at each accepted register write.
    logic                       reg_horizontal;
    logic [15:0]                reg_sheet_w;
    logic [15:0]                reg_sheet_h;
    logic [lrp_pkg::PAD_W-1:0]  reg_border;
    logic [lrp_pkg::PAD_W-1:0]  reg_shape;

    // Packing state that the predictor carries from one rectangle to the next.
    logic [lrp_pkg::POS_W-1:0]   pk_along;
    logic [lrp_pkg::POS_W-1:0]   pk_across;
    logic [lrp_pkg::POS_W-1:0]   pk_line;
    logic [lrp_pkg::SHEET_W-1:0] pk_sheets;
    logic                        pk_failed;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The run is bounded; the slowest legal run finishes well inside this window.
    initial
    begin
        #5ms;
        $display("%0t: timeout, %0d placements still outstanding", $time,
                 expected_places.size());
        $display("tb: failure");
        $finish;
    end

    function automatic void clear_packing();
        pk_along  = '0;
        pk_across = '0;
        pk_line   = '0;
        pk_sheets = '0;
        pk_failed = 1'b0;
    endfunction

    // Next-fit shelf placement of one rectangle. The "along" direction is the one the
    // current line grows in (x for rows, y for columns); "across" is the one lines stack in.
    function automatic placement_t place_rect(input rect_req_t req);
        placement_t res;
        longint w, h, pad, max_w, max_h;
        longint size_d, size_p, max_d, max_p;
        longint pos_d, pos_p, line, px, py;
        logic   opened;
        res    = '0;
        opened = 1'b0;
        if (req.start_of_set)
            clear_packing();
        // A sticky error freezes the packer until the next start of set.
        if (pk_failed)
        begin
            res.sheet_index = pk_sheets;
            res.not_placed  = 1'b1;
            return res;
        end
        w     = longint'(req.rect_width) & COORD_MASK;
        h     = longint'(req.rect_height) & COORD_MASK;
        pad   = longint'(reg_shape);
        // The usable extent goes negative when the border eats the whole sheet.
        max_w = longint'(reg_sheet_w) - 2 * longint'(reg_border);
        max_h = longint'(reg_sheet_h) - 2 * longint'(reg_border);
        size_d = reg_horizontal ? w : h;
        size_p = reg_horizontal ? h : w;
        max_d  = reg_horizontal ? max_w : max_h;
        max_p  = reg_horizontal ? max_h : max_w;
        pos_d  = longint'(pk_along);
        pos_p  = longint'(pk_across);
        line   = longint'(pk_line);
        if (pos_d + size_d > max_d)
        begin
            pos_d = 0;
            pos_p = pos_p + line;
            line  = 0;
        end
        if (pos_p + size_p > max_p)
        begin
            pk_sheets = pk_sheets + 1'b1;
            opened    = 1'b1;
            pos_d     = 0;
            pos_p     = 0;
            line      = 0;
        end
        px = reg_horizontal ? pos_d : pos_p;
        py = reg_horizontal ? pos_p : pos_d;
        if (px + w > max_w || py + h > max_h)
        begin
            pk_failed = 1'b1;
            pk_along  = pos_d[lrp_pkg::POS_W-1:0];
            pk_across = pos_p[lrp_pkg::POS_W-1:0];
            pk_line   = line[lrp_pkg::POS_W-1:0];
            res.sheet_index = pk_sheets;
            res.not_placed  = 1'b1;
            return res;
        end
        px = px + longint'(reg_border);
        py = py + longint'(reg_border);
        res.place_x     = px[lrp_pkg::PLACE_W-1:0];
        res.place_y     = py[lrp_pkg::PLACE_W-1:0];
        res.sheet_index = pk_sheets;
        res.new_sheet   = opened;
        pos_d = pos_d + size_d + pad;
        if (size_p + pad > line)
            line = size_p + pad;
        pk_along  = pos_d[lrp_pkg::POS_W-1:0];
        pk_across = pos_p[lrp_pkg::POS_W-1:0];
        pk_line   = line[lrp_pkg::POS_W-1:0];
        return res;
    endfunction

    // Request driver. Each accepted request is run through the predictor at the edge
    // where it is taken, so the expected placements stay in acceptance order. The valid
    // line is assigned at most once per edge, so back-to-back requests keep it high.
    always @(posedge clk or negedge rst_n)
    begin : rect_driver
        rect_req_t nxt;
        logic      offering;
        if (!rst_n)
        begin
            rect_bus.valid        <= 1'b0;
            rect_bus.start_of_set <= 1'b0;
            rect_bus.rect_width   <= '0;
            rect_bus.rect_height  <= '0;
        end
        else
        begin
            offering = rect_bus.valid;
            if (rect_bus.valid && rect_bus.ready)
            begin
                nxt.start_of_set = rect_bus.start_of_set;
                nxt.rect_width   = rect_bus.rect_width;
                nxt.rect_height  = rect_bus.rect_height;
                expected_places = {expected_places, place_rect(nxt)};
                offering = 1'b0;
            end
            // A request already on the bus stays there until taken; only a free bus
            // may pick up the next one or go idle.
            if (!offering)
            begin
                if (pending_rects.size() != 0 && !send_hold &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_rects.pop_front();
                    rect_bus.valid        <= 1'b1;
                    rect_bus.start_of_set <= nxt.start_of_set;
                    rect_bus.rect_width   <= nxt.rect_width;
                    rect_bus.rect_height  <= nxt.rect_height;
                end
                else
                begin
                    rect_bus.valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_field(input string name, input longint unsigned want,
                                input longint unsigned got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Placement monitor: checks each accepted placement against the oldest expectation
    // and randomizes ready, unless a long receiver hold-off is in progress.
    always @(posedge clk or negedge rst_n)
    begin : place_monitor
        placement_t want;
        if (!rst_n)
        begin
            place_bus.ready <= 1'b0;
        end
        else
        begin
            if (place_bus.valid && place_bus.ready)
            begin
                if (expected_places.size() == 0)
                begin
                    $display("%0t: unexpected placement x=%0d y=%0d sheet=%0d", $time,
                             place_bus.place_x, place_bus.place_y, place_bus.sheet_index);
                    mismatches++;
                end
                else
                begin
                    want = expected_places.pop_front();
                    report_field("place_x", want.place_x, place_bus.place_x);
                    report_field("place_y", want.place_y, place_bus.place_y);
                    report_field("sheet_index", want.sheet_index, place_bus.sheet_index);
                    report_field("new_sheet", want.new_sheet, place_bus.new_sheet);
                    report_field("not_placed", want.not_placed, place_bus.not_placed);
                    placements_checked++;
                    sheets_opened += want.new_sheet;
                    rejects_seen  += want.not_placed;
                end
            end
            place_bus.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_rect(input logic start, input logic [15:0] w, input logic [15:0] h);
        rect_req_t req;
        req.start_of_set = start;
        req.rect_width   = w;
        req.rect_height  = h;
        pending_rects = {pending_rects, req};
    endtask

    // Waits until every request has been taken and every placement has come back.
    // The check runs on the falling edge, when the driver and monitor have settled.
    task automatic wait_drained();
        while (pending_rects.size() != 0 || rect_bus.valid || expected_places.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input lrp_pkg::cfg_index_t idx, input logic [15:0] value);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (idx)
            lrp_pkg::CFG_HORIZONTAL:       reg_horizontal = value[0];
            lrp_pkg::CFG_SHEET_MAX_WIDTH:  reg_sheet_w    = value;
            lrp_pkg::CFG_SHEET_MAX_HEIGHT: reg_sheet_h    = value;
            lrp_pkg::CFG_BORDER_PAD:       reg_border     = value[lrp_pkg::PAD_W-1:0];
            lrp_pkg::CFG_GAP_PAD:          reg_shape      = value[lrp_pkg::PAD_W-1:0];
            default: ;
        endcase
    endtask

    // Registers are only touched once the block has gone quiet.
    task automatic program_sheet(input logic horiz, input logic [15:0] sheet_w,
                                 input logic [15:0] sheet_h, input logic [15:0] border,
                                 input logic [15:0] shape);
        wait_drained();
        write_reg(lrp_pkg::CFG_HORIZONTAL, {15'd0, horiz});
        write_reg(lrp_pkg::CFG_SHEET_MAX_WIDTH, sheet_w);
        write_reg(lrp_pkg::CFG_SHEET_MAX_HEIGHT, sheet_h);
        write_reg(lrp_pkg::CFG_BORDER_PAD, border);
        write_reg(lrp_pkg::CFG_GAP_PAD, shape);
    endtask

    // Most sizes are a fraction of the usable extent so lines and sheets fill up over
    // several requests; a few may reach the whole extent and a few are any 16-bit value.
    function automatic logic [15:0] draw_size(input longint usable);
        int unsigned pick;
        int unsigned span;
        pick = $urandom_range(99);
        span = (usable < 16) ? 16 : ((usable > 65535) ? 65535 : int'(usable));
        if (pick < 3)
            return 16'($urandom_range(16'hFFFF));
        else if (pick < 10)
            return 16'($urandom_range(span));
        else
            return 16'($urandom_range(span / 4));
    endfunction

    task automatic queue_random(input int count);
        longint use_w;
        longint use_h;
        use_w = longint'(reg_sheet_w) - 2 * longint'(reg_border);
        use_h = longint'(reg_sheet_h) - 2 * longint'(reg_border);
        repeat (count)
            queue_rect($urandom_range(99) < 6, draw_size(use_w), draw_size(use_h));
    endtask

    initial
    begin : stimulus
        int phase;
        // Every input of the block gets a known value before reset is released.
        rst_n          = 1'b0;
        cfg_bus.valid  = 1'b0;
        cfg_bus.index  = lrp_pkg::CFG_HORIZONTAL;
        cfg_bus.data   = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_hold      = 1'b0;
        recv_hold      = 1'b0;
        mismatches         = 0;
        placements_checked = 0;
        sheets_opened      = 0;
        rejects_seen       = 0;
        reg_horizontal = 1'b1;
        reg_sheet_w    = 16'd4096;
        reg_sheet_h    = 16'd4096;
        reg_border     = '0;
        reg_shape      = '0;
        clear_packing();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first on the reset defaults: a 4096 square sheet, rows.
        queue_rect(1'b1, 16'd0, 16'd0);
        queue_rect(1'b0, 16'd4096, 16'd10);         // fills the first row exactly
        queue_rect(1'b0, 16'd1, 16'd1);             // overruns the row, new line
        queue_rect(1'b0, 16'd4096, 16'd4086);       // overruns the sheet, opens sheet 1
        queue_rect(1'b0, 16'hFFFF, 16'd1);          // too wide for any sheet
        queue_rect(1'b0, 16'd5, 16'd5);             // error is sticky
        queue_rect(1'b1, 16'd4096, 16'd4096);       // restart clears the error
        queue_rect(1'b0, 16'd1, 16'hFFFF);          // fails right after a sheet advance
        queue_rect(1'b1, 16'hAAAA, 16'h5555);
        queue_rect(1'b1, 16'h5555, 16'hAAAA);

        // Border padding larger than half the sheet: nothing fits, not even an empty box.
        program_sheet(1'b0, 16'd2000, 16'd1000, 16'd1023, 16'd0);
        queue_rect(1'b1, 16'd0, 16'd0);
        queue_rect(1'b1, 16'd1, 16'd1);

        // Columns with both paddings on a small sheet.
        program_sheet(1'b0, 16'd300, 16'd200, 16'd20, 16'd9);
        queue_rect(1'b1, 16'd50, 16'd100);
        queue_rect(1'b0, 16'd60, 16'd70);
        queue_rect(1'b0, 16'd40, 16'd30);
        queue_rect(1'b0, 16'd260, 16'd160);
        queue_rect(1'b0, 16'd10, 16'd10);

        // Largest sheet and shape padding: a full-size box, then another that must move.
        program_sheet(1'b1, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1023);
        queue_rect(1'b1, 16'hFFFF, 16'hFFFF);
        queue_rect(1'b0, 16'hFFFF, 16'hFFFF);
        queue_rect(1'b0, 16'd0, 16'd0);

        // Zero-size sheet: only empty boxes fit.
        program_sheet(1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
        queue_rect(1'b1, 16'd0, 16'd0);
        queue_rect(1'b0, 16'd0, 16'd0);
        queue_rect(1'b0, 16'd1, 16'd0);

        // Random part: six phases of about a hundred requests, each with its own sheet
        // setup, cycling through the idling profiles.
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: program_sheet(1'b1, 16'd1000, 16'd800, 16'd10, 16'd5);
                1: program_sheet(1'b0, 16'd640, 16'd2000, 16'd3, 16'd0);
                2: program_sheet(1'($urandom_range(1)), 16'($urandom_range(200, 65535)),
                                 16'($urandom_range(200, 65535)), 16'($urandom_range(60)),
                                 16'($urandom_range(1023)));
                3: program_sheet(1'b1, 16'hFFFF, 16'hFFFF, 16'd1023, 16'd1023);
                4: program_sheet(1'b0, 16'd120, 16'hFFFF, 16'd7, 16'd1);
                default: program_sheet(1'($urandom_range(1)), 16'($urandom_range(65535)),
                                       16'($urandom_range(65535)),
                                       16'($urandom_range(1023)),
                                       16'($urandom_range(1023)));
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            if (phase == 3)
            begin
                // The receiver holds off for a long stretch while requests keep coming,
                // so the internal queue fills and the request side gets stalled.
                fork
                    begin
                        @(posedge clk);
                        recv_hold <= 1'b1;
                        repeat (200) @(posedge clk);
                        recv_hold <= 1'b0;
                    end
                join_none
                queue_random(60);
                wait fork;
                // Then the sender stops with requests still waiting, until the block
                // has returned everything it owes.
                repeat (10) @(posedge clk);
                send_hold <= 1'b1;
                @(posedge clk);
                while (rect_bus.valid || expected_places.size() != 0)
                    @(posedge clk);
                send_hold <= 1'b0;
                queue_random(40);
            end
            else
            begin
                queue_random(100);
            end
        end

        wait_drained();
        $display("summary: %0d placements checked over row, column, tiny and oversized sheets",
                 placements_checked);
        $display("summary: %0d opened a sheet, %0d rejected, under idle and stall mixes",
                 sheets_opened, rejects_seen);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
design/lrp_pkg.sv
design/lrp_rect_if.sv
design/lrp_place_if.sv
design/lrp_cfg_if.sv
design/lrp_front.sv
design/lrp_queue.sv
design/lrp_back.sv
design/line_rectangle_packer.sv
verif/tb_top.sv
